[sv/string_hash_table_probe_assert.svh]
// Assertion macros used by the port-level checker file.
`ifndef STRING_HASH_TABLE_PROBE_ASSERT_SVH
`define STRING_HASH_TABLE_PROBE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SHTP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("shtp assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SHTP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("shtp assertion failed");

`endif

[sv/shtp_pkg.sv]
// Shared types, constants and functions of the string hash table probe.
package shtp_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int MAX_NAME_DEF    = 32;
    localparam int CFG_W           = 9;
    localparam int CHAR_W          = 8;
    localparam int HASH_W          = 32;
    localparam int STATUS_W        = 3;
    localparam int SLOT_OUT_W      = 8;
    localparam int OUT_TDATA_W     = 16;
    localparam logic [CFG_W-1:0] TS_RESET = 9'd256;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_TOO_LONG  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_PROBE,
        S_LEN_CHK,
        S_CMP_RD,
        S_CMP_CHK,
        S_STEP,
        S_COPY_RD,
        S_COPY_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    div_first;
        logic    div_next;
        logic    load_slot;
        logic    steps_clr;
        logic    steps_inc;
        logic    idx_clr;
        logic    idx_inc;
        logic    len_wr;
        logic    copy_wr;
        logic    set_occ;
        logic    res_load;
        t_status res_status;
        logic    res_use_slot;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic too_long;
        logic div_done;
        logic occ;
        logic steps_done;
        logic len_eq;
        logic char_eq;
        logic idx_last;
        logic kind;
        logic out_free;
    } t_dp_stat;

    // Per-character hash value, wraps mod 2^32.
    function automatic logic [HASH_W-1:0] char_value(input logic [CHAR_W-1:0] c);
        logic [HASH_W-1:0] cx;
        cx = HASH_W'(c);
        if (c >= 8'd65 && c <= 8'd90) begin
            char_value = cx - 32'd65 + 32'd26;
        end else begin
            char_value = cx - 32'd97;
        end
    endfunction

endpackage

[sv/shtp_ram.sv]
// Generic simple dual-port RAM, one write port, one registered read port.
module shtp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[sv/shtp_rem.sv]
// Bit-serial remainder unit: 32-bit dividend mod a narrow divisor.
module shtp_rem
    import shtp_pkg::*;
#(
    parameter int DVS_W = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [HASH_W-1:0] i_dividend,
    input  logic [DVS_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [DVS_W-1:0]  o_rem
);

    logic              r_busy;
    logic              r_done;
    logic [4:0]        r_cnt;
    logic [DVS_W-1:0]  r_rem;
    logic [HASH_W-1:0] r_dvd;
    logic [DVS_W:0]    trial;
    logic [DVS_W-1:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[HASH_W-1]};
        if (trial >= {1'b0, i_divisor}) begin
            n_rem = DVS_W'(trial - {1'b0, i_divisor});
        end else begin
            n_rem = trial[DVS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[HASH_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

[sv/shtp_datapath.sv]
// Datapath: hash, name buffer, table stores, probe slot and result register.
module shtp_datapath
    import shtp_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int MAX_NAME    = MAX_NAME_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_char_acc,
    input  logic [CHAR_W-1:0]      i_char,
    input  logic                   i_kind,
    input  logic                   i_cfg_we,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  t_dp_cmd                i_cmd,
    output t_dp_stat               o_stat,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [OUT_TDATA_W-1:0] o_out_data
);

    localparam int SW  = $clog2(TABLE_DEPTH);
    localparam int TW  = $clog2(TABLE_DEPTH + 1);
    localparam int CW  = $clog2(MAX_NAME + 2);
    localparam int BW  = $clog2(MAX_NAME);
    localparam int SDP = TABLE_DEPTH * MAX_NAME;
    localparam int AW  = $clog2(SDP);

    logic [CFG_W-1:0]  r_ts;
    logic [TW-1:0]     ts_eff;
    logic [HASH_W-1:0] r_hash;
    logic [4:0]        r_shift;
    logic [CW-1:0]     r_count;
    logic              r_kind;
    logic [SW-1:0]     r_slot;
    logic [TW-1:0]     r_steps;
    logic [BW-1:0]     r_idx;
    logic [TABLE_DEPTH-1:0] r_occ;
    t_status           r_res_status;
    logic [SW-1:0]     r_res_slot;
    logic              r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic              div_start;
    logic [HASH_W-1:0] div_dvd;
    logic              div_done;
    logic [TW-1:0]     div_rem;
    logic [15:0]       next_sum;
    logic [AW-1:0]     store_addr;
    logic [CHAR_W-1:0] buf_rd;
    logic [CHAR_W-1:0] store_rd;
    logic [CW-1:0]     len_rd;
    logic [31:0]       res_slot_ext;

    always_comb begin
        if (r_ts == '0) begin
            ts_eff = TW'(1);
        end else if (32'(r_ts) > 32'(TABLE_DEPTH)) begin
            ts_eff = TW'(TABLE_DEPTH);
        end else begin
            ts_eff = TW'(r_ts);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts <= TS_RESET;
        end else if (i_cfg_we) begin
            r_ts <= i_cfg_data;
        end
    end

    // Character-serial hash and length count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash  <= '0;
            r_shift <= '0;
            r_count <= '0;
        end else if (i_cmd.out_load) begin
            r_hash  <= '0;
            r_shift <= '0;
            r_count <= '0;
        end else if (i_char_acc) begin
            r_hash  <= r_hash ^ (char_value(i_char) << r_shift);
            r_shift <= (r_shift >= 5'd28) ? 5'd0 : r_shift + 5'd4;
            if (r_count <= CW'(MAX_NAME)) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char_acc) begin
            r_kind <= i_kind;
        end
    end

    assign next_sum  = 16'(r_slot) + r_hash[15:0] + 16'd7;
    assign div_start = i_cmd.div_first | i_cmd.div_next;
    assign div_dvd   = i_cmd.div_first ? r_hash : {16'd0, next_sum};

    shtp_rem #(.DVS_W(TW)) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (ts_eff),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_slot) begin
            r_slot <= div_rem[SW-1:0];
        end
        if (i_cmd.steps_clr) begin
            r_steps <= '0;
        end else if (i_cmd.steps_inc) begin
            r_steps <= r_steps + TW'(1);
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + BW'(1);
        end
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            r_res_slot   <= i_cmd.res_use_slot ? r_slot : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_cmd.set_occ) begin
            r_occ[r_slot] <= 1'b1;
        end
    end

    assign store_addr = AW'(r_slot) * AW'(MAX_NAME) + AW'(r_idx);

    shtp_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_NAME)) u_buf (
        .i_clk   (i_clk),
        .i_we    (i_char_acc && (r_count < CW'(MAX_NAME))),
        .i_waddr (r_count[BW-1:0]),
        .i_wdata (i_char),
        .i_raddr (r_idx),
        .o_rdata (buf_rd)
    );

    shtp_ram #(.WIDTH(CHAR_W), .DEPTH(SDP)) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.copy_wr),
        .i_waddr (store_addr),
        .i_wdata (buf_rd),
        .i_raddr (store_addr),
        .o_rdata (store_rd)
    );

    shtp_ram #(.WIDTH(CW), .DEPTH(TABLE_DEPTH)) u_len (
        .i_clk   (i_clk),
        .i_we    (i_cmd.len_wr),
        .i_waddr (r_slot),
        .i_wdata (r_count),
        .i_raddr (r_slot),
        .o_rdata (len_rd)
    );

    // Output register, holds a result until the sink takes it.
    assign res_slot_ext = 32'(r_res_slot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {5'd0, res_slot_ext[SLOT_OUT_W-1:0], r_res_status};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        o_stat.too_long   = r_count > CW'(MAX_NAME);
        o_stat.div_done   = div_done;
        o_stat.occ        = r_occ[r_slot];
        o_stat.steps_done = r_steps == ts_eff;
        o_stat.len_eq     = len_rd == r_count;
        o_stat.char_eq    = store_rd == buf_rd;
        o_stat.idx_last   = (CW'(r_idx) + CW'(1)) == r_count;
        o_stat.kind       = r_kind;
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

endmodule

[sv/shtp_ctrl.sv]
// Controller: sequences hashing, probe walk, name compare and insert copy.
module shtp_ctrl
    import shtp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_last,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && i_in_last) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (i_stat.too_long) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_TOO_LONG;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.div_first = 1'b1;
                    o_cmd.steps_clr = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.load_slot = 1'b1;
                    n_state         = S_PROBE;
                end
            end
            S_PROBE: begin
                o_cmd.idx_clr = 1'b1;
                if (i_stat.steps_done || !i_stat.occ) begin
                    if (i_stat.kind && !i_stat.steps_done) begin
                        o_cmd.len_wr = 1'b1;
                        n_state      = S_COPY_RD;
                    end else begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = i_stat.kind ? ST_FULL : ST_NOT_FOUND;
                        n_state          = S_DONE;
                    end
                end else begin
                    n_state = S_LEN_CHK;
                end
            end
            S_LEN_CHK: begin
                n_state = i_stat.len_eq ? S_CMP_RD : S_STEP;
            end
            S_CMP_RD: begin
                n_state = S_CMP_CHK;
            end
            S_CMP_CHK: begin
                if (!i_stat.char_eq) begin
                    n_state = S_STEP;
                end else if (i_stat.idx_last) begin
                    o_cmd.res_load     = 1'b1;
                    o_cmd.res_status   = ST_FOUND;
                    o_cmd.res_use_slot = 1'b1;
                    n_state            = S_DONE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_CMP_RD;
                end
            end
            S_STEP: begin
                o_cmd.steps_inc = 1'b1;
                o_cmd.div_next  = 1'b1;
                n_state         = S_DIV;
            end
            S_COPY_RD: begin
                n_state = S_COPY_WR;
            end
            S_COPY_WR: begin
                o_cmd.copy_wr = 1'b1;
                if (i_stat.idx_last) begin
                    o_cmd.set_occ      = 1'b1;
                    o_cmd.res_load     = 1'b1;
                    o_cmd.res_status   = ST_INSERTED;
                    o_cmd.res_use_slot = 1'b1;
                    n_state            = S_DONE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_COPY_RD;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[sv/string_hash_table_probe.sv]
// Top level: open-addressing name table with a character-serial hash.
// Each character transfer takes one cycle while idle; the hash folds on the fly.
// After the last character the remainder unit maps the hash to the first slot; each
// extra probe step reruns it, names are compared and inserts copied one character at
// a time; the input reopens the cycle after the result is loaded.
// Synchronous active-low reset empties the table, sets table_size to 256.
module string_hash_table_probe
    import shtp_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int MAX_NAME    = MAX_NAME_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input characters.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [CHAR_W-1:0]      s_axis_tdata,   // [7:0] char_code
    input  logic                   s_axis_tlast,   // last character of the name
    input  logic [0:0]             s_axis_tuser,   // [0] kind: 0 test, 1 insert
    // Results, one per name.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [2:0] status, [10:3] slot_index
    // table_size register write.
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     char_acc;

    // A character transfer is taken only while the controller is idle.
    assign char_acc    = s_axis_tvalid && s_axis_tready;
    // Register writes must only be issued while idle; not enforced here, so always take them.
    assign o_cfg_ready = 1'b1;

    shtp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    shtp_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_NAME    (MAX_NAME)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char_acc  (char_acc),
        .i_char      (s_axis_tdata),
        .i_kind      (s_axis_tuser[0]),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

[sv/shtp_checker.sv]
// Port-level checker for the string hash table probe, bound to the top level.
`include "string_hash_table_probe_assert.svh"

module shtp_checker
    import shtp_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   s_axis_tlast,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic                  out_stall;
    logic                  out_no_slot;
    logic                  last_xfer;
    logic [STATUS_W-1:0]   out_status;
    logic [SLOT_OUT_W-1:0] out_slot;

    assign out_stall   = m_axis_tvalid && !m_axis_tready;
    assign out_status  = m_axis_tdata[STATUS_W-1:0];
    assign out_slot    = m_axis_tdata[STATUS_W +: SLOT_OUT_W];
    assign out_no_slot = (out_status == ST_NOT_FOUND) || (out_status == ST_FULL)
                         || (out_status == ST_TOO_LONG);
    assign last_xfer   = s_axis_tvalid && s_axis_tready && s_axis_tlast;

    // A stalled result stays put.
    `SHTP_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

    // Miss, full and too-long results carry slot zero.
    `SHTP_ASSERT_NOW(a_slot_zero, m_axis_tvalid && out_no_slot, out_slot == '0)

    // The last character starts a probe, so input is closed next cycle.
    `SHTP_ASSERT_NEXT(a_last_closes, last_xfer, !s_axis_tready)

endmodule

bind string_hash_table_probe shtp_checker u_shtp_checker (.*);

[tb/string_hash_table_probe_test.sv]
// Testbench for the string hash table probe: directed and random names.
`timescale 1ns / 1ps

module string_hash_table_probe_test;
    import shtp_pkg::*;

    // Model widths and limits.
    localparam int DEPTH    = 256;
    localparam int NAME_MAX = 32;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [CHAR_W-1:0]      s_axis_tdata;   // [7:0] char_code
    logic                   s_axis_tlast;   // last character of the name
    logic [0:0]             s_axis_tuser;   // [0] kind: 0 test, 1 insert
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [2:0] status, [10:3] slot_index
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_W-1:0]       i_cfg_data;

    string_hash_table_probe u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    typedef struct packed {
        t_status        status;
        logic [7:0]     slot;
    } t_lookup;

    // Predictor state: a mirror of the table and the name in progress.
    logic [8:0]  size_reg;
    logic        occ_mirror [DEPTH];
    logic [7:0]  name_mirror [DEPTH][NAME_MAX];
    int          len_mirror [DEPTH];
    logic [7:0]  cur_name [NAME_MAX];
    logic [31:0] cur_hash;
    int          cur_shift;
    int          cur_count;

    t_lookup     lookup_queue [$];
    int          error_count;
    int          name_count;
    int          result_count;
    logic        rx_hold;      // receiver long hold-off request
    logic        idle_free;    // no random idling on either side

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #1s;
        $display("string_hash_table_probe verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic int eff_size();
        if (size_reg < 1) return 1;
        if (size_reg > DEPTH) return DEPTH;
        return int'(size_reg);
    endfunction

    // Folds one character into the predictor; returns 1 with a result on last.
    function automatic bit predict_char(input logic [7:0] c, input bit kind,
                                        input bit last, output t_lookup res);
        logic [31:0] v;
        int ts, slot, steps;
        bit hit, same;
        if (c >= 8'd65 && c <= 8'd90) v = 32'(c) - 32'd65 + 32'd26;
        else v = 32'(c) - 32'd97;
        cur_hash ^= v << cur_shift;
        cur_shift = (cur_shift >= 28) ? 0 : cur_shift + 4;
        if (cur_count < NAME_MAX) cur_name[cur_count] = c;
        if (cur_count <= NAME_MAX) cur_count++;
        if (!last) return 0;
        res.status = ST_NOT_FOUND;
        res.slot   = '0;
        if (cur_count > NAME_MAX) begin
            res.status = ST_TOO_LONG;
        end else begin
            ts = eff_size();
            slot = int'(cur_hash % ts);
            steps = 0;
            hit = 0;
            while (steps != ts && occ_mirror[slot]) begin
                same = (len_mirror[slot] == cur_count);
                for (int i = 0; i < cur_count && same; i++)
                    if (name_mirror[slot][i] != cur_name[i]) same = 0;
                if (same) begin
                    hit = 1;
                    res.status = ST_FOUND;
                    res.slot = slot[7:0];
                    break;
                end
                steps++;
                slot = int'(((32'(slot) + cur_hash + 32'd7) & 32'hFFFF) % ts);
            end
            if (!hit && kind) begin
                if (steps != ts) begin
                    occ_mirror[slot] = 1;
                    len_mirror[slot] = cur_count;
                    for (int i = 0; i < cur_count; i++) name_mirror[slot][i] = cur_name[i];
                    res.status = ST_INSERTED;
                    res.slot = slot[7:0];
                end else begin
                    res.status = ST_FULL;
                end
            end
        end
        cur_hash = '0;
        cur_shift = 0;
        cur_count = 0;
        return 1;
    endfunction

    // Sends one character transfer, with random gaps before it.
    task automatic send_char(input logic [7:0] c, input bit kind, input bit last);
        t_lookup res;
        while (!idle_free && $urandom_range(99) < 13) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= kind;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        if (predict_char(c, kind, last, res)) begin
            lookup_queue = {lookup_queue, res};
            name_count++;
        end
    endtask

    task automatic send_name(input string s, input bit kind);
        for (int i = 0; i < s.len(); i++) send_char(s[i], kind, i == s.len() - 1);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (lookup_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [8:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        size_reg = value;
    endtask

    // Result checker and receiver stalls.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            result_count++;
            if (lookup_queue.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata, -1);
            end else begin
                t_lookup want;
                want = lookup_queue.pop_front();
                if (m_axis_tdata[2:0] !== want.status)
                    report_mismatch("status", m_axis_tdata[2:0], want.status);
                if (m_axis_tdata[10:3] !== want.slot)
                    report_mismatch("slot_index", m_axis_tdata[10:3], want.slot);
            end
        end
        m_axis_tready <= !rx_hold && (idle_free || $urandom_range(99) >= 13);
    end

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(1) != 0) ? 8'($urandom_range(65, 90))
                                        : 8'($urandom_range(97, 122));
    endfunction

    task automatic random_name(input int max_len, input bit kind);
        int n;
        n = $urandom_range(max_len, 1);
        for (int i = 0; i < n; i++)
            send_char((i == 0) ? rand_letter() : 8'($urandom_range(255)), kind, i == n - 1);
    endtask

    task automatic test_directed();
        send_name("a", 0);
        send_name("a", 1);
        send_name("a", 1);
        send_name("Z", 1);
        send_name("Zz", 0);
        send_char(8'hFF, 1, 1);
        send_char(8'h00, 1, 1);
        send_char(8'h01, 0, 1);
        send_char(8'hFF, 0, 1);
        // Longest legal name inserted and looked up, then a name four bytes too long.
        for (int i = 0; i < NAME_MAX; i++) send_char(8'(128 + i), 1, i == NAME_MAX - 1);
        for (int i = 0; i < NAME_MAX; i++) send_char(8'(128 + i), 0, i == NAME_MAX - 1);
        for (int i = 0; i <= NAME_MAX + 3; i++) send_char(8'h41, 1, i == NAME_MAX + 3);
    endtask

    // Tiny tables: fill up, probe exhaustion, size 0 acting as 1, 511 clamped to 256.
    task automatic test_small_tables();
        write_size(9'd1);
        repeat (4) random_name(3, 1);
        send_name("a", 0);
        write_size(9'd0);
        repeat (3) random_name(3, 1);
        write_size(9'd3);
        repeat (8) random_name(4, 1);
        write_size(9'd511);
        send_name("a", 0);
    endtask

    // Receiver holds off while the sender keeps offering names.
    task automatic test_backpressure();
        rx_hold = 1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                rx_hold = 0;
            end
            begin
                repeat (12) random_name(6, 1);
                s_axis_tvalid <= 1'b0;
            end
        join
        wait_drained();
    endtask

    task automatic test_random();
        int n;
        string pool [16];
        foreach (pool[i]) begin
            pool[i] = "";
            n = $urandom_range(6, 1);
            for (int j = 0; j < n; j++) pool[i] = {pool[i], string'(rand_letter())};
        end
        for (int phase = 0; phase < 4; phase++) begin
            write_size((phase == 0) ? 9'd256 : 9'($urandom_range(255, 2)));
            idle_free = (phase == 2);
            repeat (15) begin
                case ($urandom_range(9))
                    0:       random_name(40, $urandom_range(1));
                    1, 2, 3: send_name(pool[$urandom_range(15)], $urandom_range(1));
                    default: random_name(8, $urandom_range(1));
                endcase
            end
        end
        idle_free = 0;
        write_size(9'd256);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        s_axis_tuser  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        rx_hold = 0;
        idle_free = 0;
        error_count = 0;
        name_count = 0;
        result_count = 0;
        size_reg = TS_RESET;
        foreach (occ_mirror[i]) occ_mirror[i] = 0;
        cur_hash = '0;
        cur_shift = 0;
        cur_count = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_small_tables();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (200) @(posedge i_clk);

        $display("Covered %0d names and %0d results over table sizes 0..511,",
                 name_count, result_count);
        $display("including too-long names, full tables and a long receiver stall.");
        if (error_count == 0 && lookup_queue.size() == 0) begin
            $display("string_hash_table_probe verification clean");
        end else begin
            $display("string_hash_table_probe verification failed");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/shtp_pkg.sv
sv/shtp_ram.sv
sv/shtp_rem.sv
sv/shtp_datapath.sv
sv/shtp_ctrl.sv
sv/string_hash_table_probe.sv
sv/shtp_checker.sv
tb/string_hash_table_probe_test.sv
